@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSDS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssds assertion failed");

// Next-cycle implication, disabled during reset.
`define SSDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssds assertion failed");

`endif

@@ rtl/ssds_pkg.sv @@
// Types, constants and helper functions of the servo sweep dwell sequencer.
package ssds_pkg;

   localparam int POS_W      = 16;
   localparam int COUNT_W    = 8;
   localparam int CMP_W      = 12;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [1:0] {
      MODE_COLLECT,
      MODE_TO_INSERT,
      MODE_INSERT,
      MODE_TO_COLLECT
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_LOW,
      CSR_POS_HIGH,
      CSR_RAMP_STEP,
      CSR_INSERT_DWELL,
      CSR_COLLECT_DWELL,
      CSR_INSERT_HOLD,
      CSR_COLLECT_HOLD,
      CSR_UNUSED
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0]   pos_low;
      logic [POS_W-1:0]   pos_high;
      logic [POS_W-1:0]   ramp_step;
      logic [COUNT_W-1:0] insert_dwell;
      logic [COUNT_W-1:0] collect_dwell;
      logic [COUNT_W-1:0] insert_hold;
      logic [COUNT_W-1:0] collect_hold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pos_low:       16'd2559,
      pos_high:      16'd3519,
      ramp_step:     16'd32,
      insert_dwell:  8'd40,
      collect_dwell: 8'd10,
      insert_hold:   8'd12,
      collect_hold:  8'd4
   };

   localparam logic [POS_W-1:0]   CMP_ZERO_BELOW = 16'd2240;
   localparam logic [POS_W-1:0]   CMP_MIN        = 16'd2560;
   localparam logic [POS_W-1:0]   CMP_MAX        = 16'd3520;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
   localparam logic [POS_W-1:0]   POS_MAX        = '1;

   function automatic logic [CMP_W-1:0] clamp_compare(input logic [POS_W-1:0] p);
      logic [CMP_W-1:0] res;
      if (p < CMP_ZERO_BELOW) begin
         res = '0;
      end else if (p < CMP_MIN) begin
         res = CMP_MIN[CMP_W-1:0];
      end else if (p > CMP_MAX) begin
         res = CMP_MAX[CMP_W-1:0];
      end else begin
         res = p[CMP_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/servo_sweep_dwell_sequencer_unit.sv @@
// Servo sweep dwell sequencer: one tick request in, one servo state response out.
//
// Usage:
//   Each request on req_ carries one PWM-period tick with the wanted end
//   position (req_target_insert). Each request yields exactly one response
//   on rsp_ with the mode, the drive enable, the compare value and the raw
//   position after that tick.
//   The response is valid on the cycle after the request is taken.
//   Throughput is one request per cycle while no response waits under
//   rsp_stall; the single update step between the state registers and
//   the response register sets that figure.
//   A request is taken while the response register is empty or being
//   drained in the same cycle, so req_stall follows rsp_stall only while a
//   response is waiting.
//   The csr_ port writes one setting per cycle with no wait; write only
//   while no request is in flight.
//   Reset (synchronous) returns all settings to their defaults, the mode to
//   collect, and the dwell count, position and compare value to zero; the
//   response register is emptied.
module servo_sweep_dwell_sequencer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_target_insert,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_mode,
   output logic                            rsp_drive_enable,
   output logic [ssds_pkg::CMP_W-1:0]      rsp_pulse_compare,
   output logic [ssds_pkg::POS_W-1:0]      rsp_position,
   input  logic                            csr_wr_en,
   input  logic [ssds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssds_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import ssds_pkg::*;

   cfg_type             cfg_ff;
   mode_type            mode_ff, mode_in;
   logic [COUNT_W-1:0]  dwell_ff, dwell_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CMP_W-1:0]    cmp_ff, cmp_in;
   logic                drive_in;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_mode_ff;
   logic                rsp_drive_ff;
   logic [CMP_W-1:0]    rsp_cmp_ff;
   logic [POS_W-1:0]    rsp_pos_ff;

   logic                req_take;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_POS_LOW:       cfg_ff.pos_low       <= csr_wr_data;
            CSR_POS_HIGH:      cfg_ff.pos_high      <= csr_wr_data;
            CSR_RAMP_STEP:     cfg_ff.ramp_step     <= csr_wr_data;
            CSR_INSERT_DWELL:  cfg_ff.insert_dwell  <= csr_wr_data[COUNT_W-1:0];
            CSR_COLLECT_DWELL: cfg_ff.collect_dwell <= csr_wr_data[COUNT_W-1:0];
            CSR_INSERT_HOLD:   cfg_ff.insert_hold   <= csr_wr_data[COUNT_W-1:0];
            CSR_COLLECT_HOLD:  cfg_ff.collect_hold  <= csr_wr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // one tick update
   always_comb begin
      mode_type           mode_t;
      logic [COUNT_W-1:0] dwell_t;
      logic [POS_W:0]     sum;

      mode_t  = mode_ff;
      dwell_t = dwell_ff;
      case (mode_ff)
         MODE_COLLECT: begin
            if (dwell_ff >= cfg_ff.collect_dwell && req_target_insert) begin
               mode_t = MODE_TO_INSERT;
            end
         end
         MODE_TO_INSERT: begin
            if (pos_ff <= cfg_ff.pos_low) begin
               mode_t  = MODE_INSERT;
               dwell_t = '0;
            end
         end
         MODE_INSERT: begin
            if (dwell_ff >= cfg_ff.insert_dwell && !req_target_insert) begin
               mode_t = MODE_TO_COLLECT;
            end
         end
         default: begin
            if (pos_ff >= cfg_ff.pos_high) begin
               mode_t  = MODE_COLLECT;
               dwell_t = '0;
            end
         end
      endcase

      sum      = {1'b0, pos_ff} + {1'b0, cfg_ff.ramp_step};
      pos_in   = pos_ff;
      dwell_in = dwell_t;
      case (mode_t)
         MODE_COLLECT: begin
            pos_in = cfg_ff.pos_high;
            if (dwell_t != COUNT_MAX) dwell_in = dwell_t + 1'b1;
         end
         MODE_TO_INSERT: begin
            pos_in = (pos_ff >= cfg_ff.ramp_step) ? pos_ff - cfg_ff.ramp_step : '0;
         end
         MODE_INSERT: begin
            pos_in = cfg_ff.pos_low;
            if (dwell_t != COUNT_MAX) dwell_in = dwell_t + 1'b1;
         end
         default: begin
            pos_in = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
         end
      endcase
      mode_in = mode_t;

      if ((mode_t == MODE_COLLECT && dwell_in > cfg_ff.collect_hold) ||
          (mode_t == MODE_INSERT && dwell_in > cfg_ff.insert_hold)) begin
         drive_in = 1'b0;
         cmp_in   = cmp_ff;
      end else begin
         drive_in = 1'b1;
         cmp_in   = clamp_compare(pos_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_COLLECT;
         dwell_ff     <= '0;
         pos_ff       <= '0;
         cmp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            mode_ff  <= mode_in;
            dwell_ff <= dwell_in;
            pos_ff   <= pos_in;
            cmp_ff   <= cmp_in;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_mode_ff  <= mode_in;
         rsp_drive_ff <= drive_in;
         rsp_cmp_ff   <= cmp_in;
         rsp_pos_ff   <= pos_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_drive_enable  = rsp_drive_ff;
   assign rsp_pulse_compare = rsp_cmp_ff;
   assign rsp_position      = rsp_pos_ff;

endmodule

@@ rtl/ssds_checker.sv @@
// Port-level checker for the servo sweep dwell sequencer, with its bind.
`include "assert_macros.svh"

module ssds_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_mode,
   input logic                       rsp_drive_enable,
   input logic [ssds_pkg::CMP_W-1:0] rsp_pulse_compare
);
   import ssds_pkg::*;

   logic cmp_legal;

   assign cmp_legal = rsp_pulse_compare == '0 ||
      (rsp_pulse_compare >= CMP_MIN[CMP_W-1:0] && rsp_pulse_compare <= CMP_MAX[CMP_W-1:0]);

   // a taken request always shows a response next cycle
   `SSDS_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_valid && !req_stall, rsp_valid)

   // a waiting response is not dropped
   `SSDS_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // drive is only released at an end position
   `SSDS_ASSERT_NOW(a_release_at_end, clock, reset, rsp_valid && !rsp_drive_enable,
      rsp_mode == MODE_COLLECT || rsp_mode == MODE_INSERT)

   // a driven compare lies in the legal pulse window or is zero
   `SSDS_ASSERT_NOW(a_cmp_window, clock, reset, rsp_valid && rsp_drive_enable, cmp_legal)

endmodule

bind servo_sweep_dwell_sequencer_unit ssds_checker u_ssds_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_mode          (rsp_mode),
   .rsp_drive_enable  (rsp_drive_enable),
   .rsp_pulse_compare (rsp_pulse_compare)
);
